// ===== rtl/bspline_grid_weights_assert.svh =====
// assertion macros shared by the spline weight rtl
// no dependencies; included by modules that carry assertions
`ifndef BSPLINE_GRID_WEIGHTS_ASSERT_SVH
`define BSPLINE_GRID_WEIGHTS_ASSERT_SVH

// same-cycle implication
`define BSW_ASSERT_NOW(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("bspline_grid_weights assertion failed");

// next-cycle implication
`define BSW_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("bspline_grid_weights assertion failed");

`endif

// ===== rtl/bsw_pkg.sv =====
// shared constants and register codes for the spline weight block
// no dependencies
package bsw_pkg;

  // default parameter values
  localparam int MAX_ORDER_DEF = 8;
  localparam int MAX_GRID_DEF  = 4096;
  localparam int FRAC_BITS_DEF = 16;

  // fixed field widths
  localparam int COORD_W    = 32;
  localparam int SCALE_W    = 32;
  localparam int WEIGHT_W   = 17;
  localparam int INDEX_W    = 12;
  localparam int ORDER_W    = 4;
  localparam int POINTS_W   = 13;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam int Q16_ONE    = 65536;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIODIC = 8'd0,
    CFG_ORDER    = 8'd1,
    CFG_POINTS   = 8'd2,
    CFG_SCALE    = 8'd3
  } cfg_reg_t;

endpackage

// ===== rtl/bsw_level.sv =====
// one order step of the b-spline weight recursion, two register stages
// depends on bsw_pkg
module bsw_level import bsw_pkg::*; #(
  parameter int MAX_ORDER = MAX_ORDER_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int LEVEL_N   = 3
) (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic [FRAC_BITS:0]                    t,
  input  logic [$clog2(MAX_ORDER+1)-1:0]        order,
  input  logic [MAX_ORDER-1:0][FRAC_BITS:0]     c_in,
  output logic [MAX_ORDER-1:0][FRAC_BITS:0]     c_out
);

  localparam int W  = FRAC_BITS + 1;
  localparam int AW = $clog2(MAX_ORDER) + FRAC_BITS;
  localparam int PW = AW + W + 1;
  localparam int HW = PW - FRAC_BITS;
  localparam int D  = LEVEL_N - 1;
  localparam int K  = HW + 4;
  localparam int QW = HW + K;
  localparam longint unsigned RECIP = ((longint'(1) << K) + longint'(D) - 1) / longint'(D);
  localparam logic [PW-1:0] RND = PW'(D) << (FRAC_BITS - 1);

  logic                              act;
  logic [MAX_ORDER-1:0][W-1:0]       cpass;

  // level applies only when the order reaches it
  always_ff @(posedge clk) begin
    if (en) begin
      act   <= (32'(order) >= LEVEL_N);
      cpass <= c_in;
    end
  end

  for (genvar i = 0; i < MAX_ORDER; i++) begin : g_tap
    logic [AW-1:0] ca;
    logic [AW-1:0] cb;
    logic [PW-1:0] p1;
    logic [PW-1:0] p2;
    logic [HW-1:0] hi;
    logic [QW-1:0] qprod;
    logic [W-1:0]  c_r;

    // left neighbor term
    if (i >= 1 && i <= LEVEL_N - 1) begin : g_left
      assign ca = AW'(t) + (AW'(LEVEL_N - 1 - i) << FRAC_BITS);
      assign p1 = PW'(ca) * PW'(c_in[i-1]);
    end else begin : g_noleft
      assign ca = '0;
      assign p1 = '0;
    end

    // own term
    if (i <= LEVEL_N - 2) begin : g_own
      assign cb = (AW'(i + 1) << FRAC_BITS) - AW'(t);
      assign p2 = PW'(cb) * PW'(c_in[i]);
    end else begin : g_noown
      assign cb = '0;
      assign p2 = '0;
    end

    // stage a: rounded sum of products
    always_ff @(posedge clk) begin
      if (en) begin
        hi <= HW'((p1 + p2 + RND) >> FRAC_BITS);
      end
    end

    // stage b: divide by the level constant through its reciprocal
    assign qprod = QW'(hi) * QW'(RECIP);

    if (i <= LEVEL_N - 1) begin : g_upd
      always_ff @(posedge clk) begin
        if (en) begin
          c_r <= act ? W'(qprod >> K) : cpass[i];
        end
      end
    end else begin : g_pass
      always_ff @(posedge clk) begin
        if (en) begin
          c_r <= cpass[i];
        end
      end
    end

    assign c_out[i] = c_r;
  end

endmodule

// ===== rtl/bspline_grid_weights.sv =====
// Throughput: one tap per cycle while out_ready holds; a coordinate gives spline_order taps on the output,
// up to 8, set by the single tap register on the output channel.
// Input takes a coordinate every cycle while the last stage is empty or the serializer takes its coordinate.
// Reset is synchronous: clears all valid bits and restores the register defaults.
// depends on bsw_pkg, bsw_level and bspline_grid_weights_assert.svh
`include "bspline_grid_weights_assert.svh"
module bspline_grid_weights import bsw_pkg::*; #(
  parameter int MAX_ORDER = MAX_ORDER_DEF,
  parameter int MAX_GRID  = MAX_GRID_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_W-1:0]    coord,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [WEIGHT_W-1:0]          weight,
  output logic [INDEX_W-1:0]           grid_index,
  output logic                         last_tap,
  output logic                         out_of_range,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  localparam int W   = FRAC_BITS + 1;
  localparam int OW  = $clog2(MAX_ORDER + 1);
  localparam int CNW = $clog2(MAX_ORDER);
  localparam int NW  = $clog2(MAX_GRID + 1);
  localparam int IW  = 34;
  localparam int NLV = MAX_ORDER - 2;
  localparam int NL  = 2 * NLV;
  localparam int MST = 5;
  localparam int BPS = 7;
  localparam int UPW = MST * BPS;
  localparam int NS  = (NL > MST) ? NL : MST;
  localparam int ND  = NS - NL;
  localparam logic [W-1:0] ONE_W  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [W-1:0] HALF_W = {2'b01, {(FRAC_BITS-1){1'b0}}};

  typedef struct packed {
    logic [W-1:0]          t;
    logic [IW-1:0]         base;
    logic [UPW-1:0]        u;
    logic                  neg;
    logic [NW-1:0]         rem;
  } side_t;

  typedef logic [MAX_ORDER-1:0][W-1:0] wvec_t;

  // configuration registers
  logic                  periodic_mode;
  logic [ORDER_W-1:0]    spline_order;
  logic [POINTS_W-1:0]   grid_points;
  logic [SCALE_W-1:0]    grid_scale;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      periodic_mode <= 1'b1;
      spline_order  <= ORDER_W'(4);
      grid_points   <= POINTS_W'(64);
      grid_scale    <= SCALE_W'(Q16_ONE);
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        CFG_PERIODIC: periodic_mode <= cfg_data[0];
        CFG_ORDER:    spline_order  <= cfg_data[ORDER_W-1:0];
        CFG_POINTS:   grid_points   <= cfg_data[POINTS_W-1:0];
        CFG_SCALE:    grid_scale    <= cfg_data[SCALE_W-1:0];
        default:      ;
      endcase
    end
  end

  // clamped order and grid size
  logic [OW-1:0] ordc;
  logic [NW-1:0] nxc;
  logic [OW-1:0] half_ord;

  always_comb begin
    if (spline_order == '0) begin
      ordc = OW'(1);
    end else if (32'(spline_order) > MAX_ORDER) begin
      ordc = OW'(MAX_ORDER);
    end else begin
      ordc = OW'(spline_order);
    end
    if (grid_points == '0) begin
      nxc = NW'(1);
    end else if (32'(grid_points) > MAX_GRID) begin
      nxc = NW'(MAX_GRID);
    end else begin
      nxc = NW'(grid_points);
    end
    half_ord = ordc >> 1;
  end

  logic en;
  logic ser_take;
  logic vs [0:NS];

  assign en       = !vs[NS] || ser_take;
  assign in_ready = en;

  // stage 1: coordinate times scale
  logic               v1;
  logic [63:0]        prod1;
  logic signed [64:0] mult;

  assign mult = $signed(coord) * $signed({1'b0, grid_scale});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod1 <= mult[63:0];
    end
  end

  // stage 2: half shift for odd orders, split into node and fraction
  logic                  v2;
  logic signed [31:0]    node2;
  logic [W-1:0]          t2;
  logic [63:0]           pos2;

  assign pos2 = ordc[0] ? (prod1 - 64'h0000_0000_8000_0000) : prod1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      node2 <= $signed(pos2[63:32]);
      t2    <= {1'b0, pos2[31 -: FRAC_BITS]};
    end
  end

  // stage 3: upper edge case, first tap node, initial weights
  logic signed [IW-1:0] node_x;
  logic signed [IW-1:0] lo_lim;
  logic                 at_edge;
  logic signed [IW-1:0] node_e;
  logic [W-1:0]         t_e;
  logic [IW-1:0]        base3;
  logic [IW-1:0]        u3;
  side_t                side3_next;
  wvec_t                c3_next;
  side_t                side0;
  wvec_t                c3;
  logic                 v3;

  always_comb begin
    node_x  = IW'(node2);
    lo_lim  = $signed(IW'(nxc >> 1) - IW'(1));
    at_edge = !periodic_mode && (node_x >= lo_lim) &&
              (IW'(node_x) + IW'(half_ord) == IW'(nxc)) && (t2 == '0);
    node_e  = at_edge ? (node_x - IW'(1)) : node_x;
    t_e     = at_edge ? ONE_W : t2;
    if (ordc == OW'(1)) begin
      base3 = (t_e < HALF_W) ? IW'(node_e) : IW'(node_e) + IW'(1);
    end else begin
      base3 = IW'(node_e) + IW'(1) - IW'(half_ord);
    end
    u3 = base3[IW-1] ? ~base3 : base3;
    side3_next.t    = t_e;
    side3_next.base = base3;
    side3_next.u    = UPW'(u3);
    side3_next.neg  = base3[IW-1];
    side3_next.rem  = '0;
    c3_next = '0;
    if (ordc == OW'(1)) begin
      c3_next[0] = ONE_W;
    end else begin
      c3_next[0] = ONE_W - t_e;
      c3_next[1] = t_e;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side0 <= side3_next;
      c3    <= c3_next;
    end
  end

  side_t side [0:NS];
  wvec_t cwl  [0:NLV];
  wvec_t cwd  [0:ND];

  assign side[0] = side0;
  assign vs[0]   = v3;
  assign cwl[0]  = c3;

  // middle stages: sideband and the modulo by grid size, bits from the top
  for (genvar k = 0; k < NS; k++) begin : g_mid
    side_t         nxt;
    side_t         side_r;
    logic          v_r;

    if (k < MST) begin : g_mod
      logic [NW:0] acc;
      always_comb begin
        nxt = side[k];
        acc = {1'b0, side[k].rem};
        for (int b = 0; b < BPS; b++) begin
          acc = {acc[NW-1:0], side[k].u[UPW-1-k*BPS-b]};
          if (acc >= {1'b0, nxc}) begin
            acc = acc - {1'b0, nxc};
          end
        end
        nxt.rem = acc[NW-1:0];
      end
    end else begin : g_nomod
      assign nxt = side[k];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= vs[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r <= nxt;
      end
    end

    assign vs[k+1]   = v_r;
    assign side[k+1] = side_r;
  end

  // weight recursion, one level per two stages
  for (genvar l = 0; l < NLV; l++) begin : g_lvl
    bsw_level #(
      .MAX_ORDER (MAX_ORDER),
      .FRAC_BITS (FRAC_BITS),
      .LEVEL_N   (l + 3)
    ) u_level (
      .clk   (clk),
      .en    (en),
      .t     (side[2*l].t),
      .order (ordc),
      .c_in  (cwl[l]),
      .c_out (cwl[l+1])
    );
  end

  // align weights with the modulo chain
  assign cwd[0] = cwl[NLV];
  for (genvar j = 0; j < ND; j++) begin : g_dly
    wvec_t d_r;
    always_ff @(posedge clk) begin
      if (en) begin
        d_r <= cwd[j];
      end
    end
    assign cwd[j+1] = d_r;
  end

  // serializer: holds one coordinate and steps through its taps
  logic                 sv;
  wvec_t                sc;
  logic [CNW-1:0]       scnt;
  logic [IW-1:0]        sidx;
  logic [NW-1:0]        rmod;
  logic [IW-1:0]        load_idx;
  logic                 out_load;
  logic                 tap_last;
  logic [W-1:0]         cur;
  logic [31:0]          c32;
  logic [31:0]          r32;
  logic [WEIGHT_W-1:0]  w_next;
  logic [NW-1:0]        idx_next;
  logic                 oor_next;
  logic [IW-1:0]        sidx_inc;
  logic [IW-1:0]        sidx_next;

  assign rmod     = side[NS].neg ? (nxc - NW'(1) - side[NS].rem) : side[NS].rem;
  assign load_idx = periodic_mode ? IW'(rmod) : side[NS].base;
  assign out_load = !out_valid || out_ready;
  assign tap_last = (OW'(scnt) == ordc - OW'(1));
  assign ser_take = !sv || (out_load && tap_last);

  // weight to unsigned q1.16 with saturation at 1.0
  assign cur = sc[scnt];
  assign c32 = 32'(cur);
  if (FRAC_BITS > 16) begin : g_rnd
    assign r32 = (c32 + (32'd1 << (FRAC_BITS - 17))) >> (FRAC_BITS - 16);
  end else begin : g_shl
    assign r32 = c32 << (16 - FRAC_BITS);
  end
  assign w_next = (r32 > 32'(Q16_ONE)) ? WEIGHT_W'(Q16_ONE) : WEIGHT_W'(r32);

  // tap index: wrap or clamp
  always_comb begin
    sidx_inc = sidx + IW'(1);
    oor_next = 1'b0;
    if (periodic_mode) begin
      idx_next  = sidx[NW-1:0];
      sidx_next = (sidx_inc == IW'(nxc)) ? '0 : sidx_inc;
    end else begin
      sidx_next = sidx_inc;
      if (sidx[IW-1]) begin
        idx_next = '0;
        oor_next = 1'b1;
      end else if ($signed(sidx) > $signed(IW'(nxc) - IW'(1))) begin
        idx_next = nxc - NW'(1);
        oor_next = 1'b1;
      end else begin
        idx_next = sidx[NW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sv <= 1'b0;
    end else if (ser_take) begin
      sv <= vs[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (ser_take) begin
      sc   <= cwd[ND];
      scnt <= '0;
      sidx <= load_idx;
    end else if (out_load) begin
      scnt <= scnt + CNW'(1);
      sidx <= sidx_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= sv;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && sv) begin
      weight       <= w_next;
      grid_index   <= INDEX_W'(idx_next);
      last_tap     <= tap_last;
      out_of_range <= oor_next;
    end
  end

  // checks
  `BSW_ASSERT_NEXT(a_ser_hold, clk, rst, sv && !ser_take, sv)
  `BSW_ASSERT_NEXT(a_stall_hold, clk, rst, vs[NS] && !en, vs[NS])
  `BSW_ASSERT_NEXT(a_out_src, clk, rst, !sv && (!out_valid || out_ready), !out_valid)
  `BSW_ASSERT_NOW(a_weight_max, clk, rst, out_valid, weight <= 17'd65536)

endmodule
